### design/bll_pkg.sv
// bll_pkg: shared types and constants of the binary-lifting ancestor block
// holds query codes, datapath commands and the status bundle
// no dependencies
package bll_pkg;

    // fixed field widths of the item ports
    localparam int FUNC_W  = 2;
    localparam int NODE_W  = 10;
    localparam int STEP_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int LEN_W   = 11;

    // depth of an attached node saturates here
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    // query codes carried by the func field
    typedef enum logic [FUNC_W-1:0] {
        FN_ATTACH = 2'd0,
        FN_LCA    = 2'd1,
        FN_KTH    = 2'd2,
        FN_DIST   = 2'd3
    } t_func;

    // datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RED,
        OP_DEP,
        OP_DEP_TAKE,
        OP_ATT_FIRST,
        OP_ATT_RD,
        OP_ATT_WR,
        OP_CL_RD,
        OP_CL_TAKE,
        OP_CMP,
        OP_TOP_RD,
        OP_TOP_TAKE,
        OP_DESC_RD,
        OP_DESC_TAKE,
        OP_PAR_RD,
        OP_PAR_TAKE,
        OP_LD_RD,
        OP_LD_TAKE,
        OP_OUT
    } t_op;

    // datapath status seen by the controller
    typedef struct packed {
        logic  clr_last;
        logic  red_last;
        logic  short_k;
        logic  att_last;
        logic  k_zero;
        logic  a_eq_b;
        logic  rounds_full;
        logic  q_diff;
        logic  lvl_zero;
        logic  out_free;
        t_func func;
    } t_stat;

endpackage

### design/bll_dp.sv
// bll_dp: datapath of the binary-lifting ancestor block
// holds the jump store, the depth store, the walk registers and the output register
// depends on bll_pkg
module bll_dp #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bll_pkg::t_op                  i_op,
    output bll_pkg::t_stat                o_stat,
    input  logic [bll_pkg::FUNC_W-1:0]    i_func,
    input  logic [bll_pkg::NODE_W-1:0]    i_node_a,
    input  logic [bll_pkg::NODE_W-1:0]    i_node_b,
    input  logic [bll_pkg::STEP_W-1:0]    i_steps,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [bll_pkg::NODE_W-1:0]    o_result_node,
    output logic [bll_pkg::LEN_W-1:0]     o_path_length,
    output logic                          o_not_found
);
    import bll_pkg::*;

    localparam int NW        = $clog2(NODES);
    localparam int LW        = $clog2(LEVELS);
    localparam int CW        = NW + LW;
    localparam int JT_DEPTH  = NODES << LW;
    localparam int CLR_LAST  = JT_DEPTH - 1;
    localparam int RED_STEPS = (NODES >= 1024) ? 1 : $clog2(1024 / NODES) + 1;
    localparam int RSW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int RED_W     = NW + RED_STEPS + 1;
    localparam int RW        = $clog2(NODES + 1);
    localparam logic [LW-1:0] TOP_LVL = LW'(LEVELS - 1);
    localparam logic [3:0]    TOP4    = 4'(LEVELS - 1);

    // highest set bit of a step count
    function automatic logic [3:0] msb_of(input logic [STEP_W-1:0] k);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < STEP_W; i++) begin
            if (k[i]) r = 4'(i);
        end
        return r;
    endfunction

    // stores
    logic [NW-1:0]      r_jump  [JT_DEPTH];
    logic [DEPTH_W-1:0] r_depth [NODES];
    logic [NW-1:0]      r_jq0, r_jq1;
    logic [DEPTH_W-1:0] r_dq0, r_dq1;

    // walk registers
    t_func              r_func;
    logic [NODE_W-1:0]  r_ra, r_rb;
    logic [STEP_W-1:0]  r_k;
    logic [RSW-1:0]     r_step;
    logic [NW-1:0]      r_a, r_b, r_cur, r_l, r_res;
    logic [DEPTH_W-1:0] r_da, r_db;
    logic [LW-1:0]      r_lvl;
    logic [RW-1:0]      r_rounds;
    logic [LEN_W-1:0]   r_len;
    logic               r_nf;
    logic [CW-1:0]      r_clr;

    // output register
    logic               r_ov;
    logic [NODE_W-1:0]  r_out_node;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_nf;

    // store port controls
    logic [CW-1:0]      w_jra0, w_jra1, w_jwa;
    logic               w_jwe;
    logic [NW-1:0]      w_jwd;
    logic [NW-1:0]      w_dra0, w_dra1, w_dwa;
    logic               w_dwe;
    logic [DEPTH_W-1:0] w_dwd;

    // climb step and reduction helpers
    logic [3:0]         w_msb, w_jfull;
    logic [LW-1:0]      w_j;
    logic [STEP_W-1:0]  w_span;
    logic [RED_W-1:0]   w_mod, w_sub_a, w_sub_b;
    logic [DEPTH_W-1:0] w_dinc;
    logic [LEN_W-1:0]   w_sum, w_twice;

    always_comb begin
        w_msb   = msb_of(r_k);
        w_jfull = (w_msb > TOP4) ? TOP4 : w_msb;
        w_j     = LW'(w_jfull);
        w_span  = STEP_W'(1) << w_jfull;
        w_mod   = RED_W'(NODES) << r_step;
        w_sub_a = RED_W'(r_ra) - w_mod;
        w_sub_b = RED_W'(r_rb) - w_mod;
        w_dinc  = (r_dq1 == DEPTH_MAX) ? DEPTH_MAX : r_dq1 + DEPTH_W'(1);
        w_sum   = LEN_W'(r_da) + LEN_W'(r_db);
        w_twice = {r_dq0, 1'b0};
    end

    // address and write selection per command
    always_comb begin
        w_jra0 = {r_a, w_j};
        w_jra1 = {r_b, r_lvl};
        w_jwe  = 1'b0;
        w_jwa  = {r_a, r_lvl + LW'(1)};
        w_jwd  = r_jq0;
        w_dra0 = r_l;
        w_dra1 = r_b;
        w_dwe  = 1'b0;
        w_dwa  = r_a;
        w_dwd  = w_dinc;
        unique case (i_op)
            OP_CLEAR: begin
                w_jwe = 1'b1;
                w_jwa = r_clr;
                w_jwd = '0;
                w_dwe = 1'b1;
                w_dwa = r_clr[CW-1:LW];
                w_dwd = '0;
            end
            OP_DEP: begin
                w_dra0 = NW'(r_ra);
                w_dra1 = NW'(r_rb);
            end
            OP_ATT_FIRST: begin
                w_dwe = 1'b1;
                w_jwe = 1'b1;
                w_jwa = {r_a, LW'(0)};
                w_jwd = r_b;
            end
            OP_ATT_RD:  w_jra0 = {r_cur, r_lvl};
            OP_ATT_WR:  w_jwe  = 1'b1;
            OP_CL_RD:   w_jra0 = {r_a, w_j};
            OP_TOP_RD: begin
                w_jra0 = {r_a, TOP_LVL};
                w_jra1 = {r_b, TOP_LVL};
            end
            OP_DESC_RD: begin
                w_jra0 = {r_a, r_lvl};
                w_jra1 = {r_b, r_lvl};
            end
            OP_PAR_RD:  w_jra0 = {r_a, LW'(0)};
            OP_LD_RD:   w_dra0 = r_l;
            default: ;
        endcase
    end

    // stores, read data registered
    always_ff @(posedge i_clk) begin
        if (w_jwe) r_jump[w_jwa] <= w_jwd;
        if (w_dwe) r_depth[w_dwa] <= w_dwd;
        r_jq0 <= r_jump[w_jra0];
        r_jq1 <= r_jump[w_jra1];
        r_dq0 <= r_depth[w_dra0];
        r_dq1 <= r_depth[w_dra1];
    end

    // control registers: clear sweep and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_op == OP_CLEAR) r_clr <= r_clr + CW'(1);
            if (i_op == OP_OUT) r_ov <= 1'b1;
            else if (!i_stall)  r_ov <= 1'b0;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_func <= t_func'(i_func);
                r_ra   <= i_node_a;
                r_rb   <= i_node_b;
                r_k    <= i_steps;
                r_res  <= '0;
                r_len  <= '0;
                r_nf   <= 1'b0;
                r_step <= RSW'(RED_STEPS - 1);
            end
            OP_RED: begin
                if (RED_W'(r_ra) >= w_mod) r_ra <= w_sub_a[NODE_W-1:0];
                if (RED_W'(r_rb) >= w_mod) r_rb <= w_sub_b[NODE_W-1:0];
                r_step <= r_step - RSW'(1);
            end
            OP_DEP: begin
                r_a <= NW'(r_ra);
                r_b <= NW'(r_rb);
            end
            OP_DEP_TAKE: begin
                r_da <= r_dq0;
                r_db <= r_dq1;
                if (r_func == FN_KTH) begin
                    r_nf <= (r_dq0 < r_k);
                end else if (r_dq0 < r_dq1) begin
                    r_a  <= r_b;
                    r_b  <= r_a;
                    r_da <= r_dq1;
                    r_db <= r_dq0;
                    r_k  <= r_dq1 - r_dq0;
                end else begin
                    r_k  <= r_dq0 - r_dq1;
                end
            end
            OP_ATT_FIRST: begin
                r_cur <= r_b;
                r_lvl <= '0;
            end
            OP_ATT_WR: begin
                r_cur <= r_jq0;
                r_lvl <= r_lvl + LW'(1);
            end
            OP_CL_RD:   r_k <= r_k - w_span;
            OP_CL_TAKE: r_a <= r_jq0;
            OP_CMP: begin
                r_l <= r_a;
                if (r_func != FN_DIST) r_res <= r_a;
                r_rounds <= '0;
                r_lvl    <= TOP_LVL;
            end
            OP_TOP_TAKE: begin
                if (r_jq0 != r_jq1) begin
                    r_a      <= r_jq0;
                    r_b      <= r_jq1;
                    r_rounds <= r_rounds + RW'(1);
                end
            end
            OP_DESC_TAKE: begin
                if (r_jq0 != r_jq1) begin
                    r_a <= r_jq0;
                    r_b <= r_jq1;
                end
                r_lvl <= r_lvl - LW'(1);
            end
            OP_PAR_TAKE: begin
                r_l <= r_jq0;
                if (r_func == FN_LCA) r_res <= r_jq0;
            end
            OP_LD_TAKE: r_len <= (w_sum >= w_twice) ? w_sum - w_twice : '0;
            OP_OUT: begin
                r_out_node <= NODE_W'(r_res);
                r_out_len  <= r_len;
                r_out_nf   <= r_nf;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.clr_last    = (r_clr == CW'(CLR_LAST));
        o_stat.red_last    = (r_step == '0);
        o_stat.short_k     = (r_dq0 < r_k);
        o_stat.att_last    = (r_lvl == LW'(LEVELS - 2));
        o_stat.k_zero      = (r_k == '0);
        o_stat.a_eq_b      = (r_a == r_b);
        o_stat.rounds_full = (r_rounds == RW'(NODES));
        o_stat.q_diff      = (r_jq0 != r_jq1);
        o_stat.lvl_zero    = (r_lvl == '0);
        o_stat.out_free    = !r_ov || !i_stall;
        o_stat.func        = r_func;
    end

    assign o_valid       = r_ov;
    assign o_result_node = r_out_node;
    assign o_path_length = r_out_len;
    assign o_not_found   = r_out_nf;

endmodule

### design/bll_ctrl.sv
// bll_ctrl: sequencer of the binary-lifting ancestor block
// steps the datapath through clear, reduce, attach, climb and search phases
// depends on bll_pkg
module bll_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bll_pkg::t_stat i_stat,
    output bll_pkg::t_op   o_op
);
    import bll_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RED,
        S_DEP,
        S_DEP_TAKE,
        S_ATT_RD,
        S_ATT_WR,
        S_CL,
        S_CL_TAKE,
        S_TOP,
        S_TOP_TAKE,
        S_DESC,
        S_DESC_TAKE,
        S_PAR,
        S_PAR_TAKE,
        S_LD,
        S_LD_TAKE,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    // next state and command
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                o_op = OP_RED;
                if (i_stat.red_last) n_state = S_DEP;
            end
            S_DEP: begin
                o_op    = OP_DEP;
                n_state = S_DEP_TAKE;
            end
            S_DEP_TAKE: begin
                if (i_stat.func == FN_ATTACH) begin
                    o_op    = OP_ATT_FIRST;
                    n_state = S_ATT_RD;
                end else begin
                    o_op = OP_DEP_TAKE;
                    if (i_stat.func == FN_KTH && i_stat.short_k) n_state = S_FIN;
                    else                                       n_state = S_CL;
                end
            end
            S_ATT_RD: begin
                o_op    = OP_ATT_RD;
                n_state = S_ATT_WR;
            end
            S_ATT_WR: begin
                o_op    = OP_ATT_WR;
                n_state = i_stat.att_last ? S_FIN : S_ATT_RD;
            end
            // climb until the remaining step count is zero
            S_CL: begin
                if (i_stat.k_zero) begin
                    o_op = OP_CMP;
                    priority if (i_stat.func == FN_KTH)    n_state = S_FIN;
                    else if (!i_stat.a_eq_b)               n_state = S_TOP;
                    else if (i_stat.func == FN_LCA)        n_state = S_FIN;
                    else                                   n_state = S_LD;
                end else begin
                    o_op    = OP_CL_RD;
                    n_state = S_CL_TAKE;
                end
            end
            S_CL_TAKE: begin
                o_op    = OP_CL_TAKE;
                n_state = S_CL;
            end
            // repeat the top jump while both tops differ and fewer than NODES rounds were made
            S_TOP: begin
                if (i_stat.rounds_full) begin
                    n_state = S_DESC;
                end else begin
                    o_op    = OP_TOP_RD;
                    n_state = S_TOP_TAKE;
                end
            end
            S_TOP_TAKE: begin
                o_op    = OP_TOP_TAKE;
                n_state = i_stat.q_diff ? S_TOP : S_DESC;
            end
            // descend one level per pass
            S_DESC: begin
                o_op    = OP_DESC_RD;
                n_state = S_DESC_TAKE;
            end
            S_DESC_TAKE: begin
                o_op    = OP_DESC_TAKE;
                n_state = i_stat.lvl_zero ? S_PAR : S_DESC;
            end
            S_PAR: begin
                o_op    = OP_PAR_RD;
                n_state = S_PAR_TAKE;
            end
            S_PAR_TAKE: begin
                o_op    = OP_PAR_TAKE;
                n_state = (i_stat.func == FN_LCA) ? S_FIN : S_LD;
            end
            S_LD: begin
                o_op    = OP_LD_RD;
                n_state = S_LD_TAKE;
            end
            S_LD_TAKE: begin
                o_op    = OP_LD_TAKE;
                n_state = S_FIN;
            end
            // hand the result over once the output register is free
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

### design/binary_lifting_lca_top.sv
// binary_lifting_lca_top: top level of the binary-lifting ancestor block
// joins the sequencer and the datapath
// depends on bll_pkg, bll_ctrl, bll_dp
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  in      | i_valid | o_stall | i_func, i_node_a, i_node_b, i_steps
//  out     | o_valid | i_stall | o_result_node, o_path_length, o_not_found
//
// after reset the stores are swept to zero, one entry a cycle, over all
// NODES * 2**ceil(log2(LEVELS)) jump entries (16384 at the defaults); o_stall is high meanwhile
// one item at a time: the load, the node reduction steps and the depth read, then a read and
// a take for every store read of the walk, plus a compare to end a query's climb and an empty
// top check at the round limit; an attach makes LEVELS-1 jump reads after the depth read
// the next item is taken while a result waits in the output register
module binary_lifting_lca_top #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bll_pkg::FUNC_W-1:0]    i_func,
    input  logic [bll_pkg::NODE_W-1:0]    i_node_a,
    input  logic [bll_pkg::NODE_W-1:0]    i_node_b,
    input  logic [bll_pkg::STEP_W-1:0]    i_steps,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bll_pkg::NODE_W-1:0]    o_result_node,
    output logic [bll_pkg::LEN_W-1:0]     o_path_length,
    output logic                          o_not_found
);
    import bll_pkg::*;

    t_op   w_op;
    t_stat w_stat;

    // sequencer
    bll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // stores and walk registers
    bll_dp #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_stat        (w_stat),
        .i_func        (i_func),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .i_steps       (i_steps),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result_node (o_result_node),
        .o_path_length (o_path_length),
        .o_not_found   (o_not_found)
    );

endmodule
